// File: hdl/lct_pkg.sv
// Shared definitions for the LRU cache table: request codes, default sizes
// and the command bundle from the controller to the datapath.
// No dependencies.
`default_nettype none

package lct_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 64;
    localparam int DEF_VALUE_BITS = 32;

    // Request kinds carried in the input tuser field
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_ERASE  = 2'd2;

    // Step commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the accepted request
        logic cmp;       // register key matches and the oldest entry
        logic upd;       // apply table update, access value memory
        logic out_load;  // move the finished result into the output register
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: hdl/lct_ctrl.sv
// Controller of the LRU cache table: steps each request through compare,
// update and result, and owns the output valid flag. Uses lct_pkg.
`default_nettype none

module lct_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output lct_pkg::t_dp_cmd       o_cmd
);
    import lct_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // Decode the step commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.cmp      = (r_state == S_CMP);
        o_cmd.upd      = (r_state == S_UPD);
        o_cmd.out_load = (r_state == S_OUT) && w_out_free;
    end

    // Advance through the steps of one item
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CMP;
            end
            S_CMP:  n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Hold the result until taken, refill when a new one is done
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: hdl/lct_dpath.sv
// Datapath of the LRU cache table: key and age cells, value memory, request
// and result registers. Driven by lct_ctrl commands; uses lct_pkg.
`default_nettype none

module lct_dpath #(
    parameter int ENTRIES    = lct_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lct_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lct_pkg::DEF_VALUE_BITS,
    parameter int OCC_W      = $clog2(ENTRIES + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lct_pkg::t_dp_cmd      i_cmd,
    input  wire logic [OCC_W-1:0]      i_capacity,
    input  wire logic [1:0]            i_action,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic                       o_hit,
    output logic [VALUE_BITS-1:0]      o_read_value,
    output logic                       o_evicted,
    output logic [KEY_BITS-1:0]        o_evicted_key,
    output logic [OCC_W-1:0]           o_occupancy
);
    import lct_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int AGE_W = $clog2(ENTRIES);

    // Table cells
    logic [ENTRIES-1:0]    r_valid;
    logic [KEY_BITS-1:0]   r_key [ENTRIES];
    logic [AGE_W-1:0]      r_age [ENTRIES];
    logic [OCC_W-1:0]      r_occ;
    logic [VALUE_BITS-1:0] r_mem [ENTRIES];
    logic [VALUE_BITS-1:0] r_rd_value;

    // Request
    logic [1:0]            r_act;
    logic [KEY_BITS-1:0]   r_req_key;
    logic [VALUE_BITS-1:0] r_req_value;

    // Compare step
    logic [ENTRIES-1:0]    r_match;
    logic [ENTRIES-1:0]    r_oldest;
    logic                  r_full;
    logic [OCC_W-1:0]      w_occ_m1;

    // Update step
    logic                  w_ins;
    logic                  w_look;
    logic                  w_erase;
    logic                  w_hit;
    logic                  w_evict;
    logic [IDX_W-1:0]      w_slot_idx;
    logic [AGE_W-1:0]      w_slot_age;
    logic [KEY_BITS-1:0]   w_ev_key;
    logic [ENTRIES-1:0]    w_free;
    logic [ENTRIES-1:0]    w_free_1h;
    logic [IDX_W-1:0]      w_free_idx;
    logic [IDX_W-1:0]      w_mem_addr;
    logic [ENTRIES-1:0]    n_valid;
    logic [AGE_W-1:0]      n_age [ENTRIES];
    logic [ENTRIES-1:0]    w_key_we;
    logic [OCC_W-1:0]      n_occ;

    // Result
    logic                  r_res_hit;
    logic                  r_res_ev;
    logic [KEY_BITS-1:0]   r_res_ev_key;
    logic                  r_o_hit;
    logic [VALUE_BITS-1:0] r_o_rv;
    logic                  r_o_ev;
    logic [KEY_BITS-1:0]   r_o_ev_key;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act       <= i_action;
            r_req_key   <= i_key;
            r_req_value <= i_value;
        end
    end

    // Compare every cell against the key; the oldest valid entry has age occ-1
    assign w_occ_m1 = r_occ - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_match[i]  <= r_valid[i] && (r_key[i] == r_req_key);
                r_oldest[i] <= r_valid[i] && (r_age[i] == w_occ_m1[AGE_W-1:0]);
            end
            r_full <= (r_occ >= i_capacity);
        end
    end

    assign w_ins   = (r_act == ACT_INSERT);
    assign w_look  = (r_act == ACT_LOOKUP);
    assign w_erase = (r_act == ACT_ERASE);
    assign w_hit   = |r_match;
    assign w_evict = w_ins && !w_hit && r_full;

    // Lowest free slot, counting the slot about to be evicted as free
    assign w_free    = ~r_valid | (w_evict ? r_oldest : '0);
    assign w_free_1h = w_free & (~w_free + 1'b1);

    // Encode the one-hot selections
    always_comb begin
        w_slot_idx = '0;
        w_slot_age = '0;
        w_ev_key   = '0;
        w_free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_match[i]) begin
                w_slot_idx = w_slot_idx | IDX_W'(i);
                w_slot_age = w_slot_age | r_age[i];
            end
            if (r_oldest[i]) begin
                w_ev_key = w_ev_key | r_key[i];
            end
            if (w_free_1h[i]) begin
                w_free_idx = w_free_idx | IDX_W'(i);
            end
        end
    end

    // Next valid bits, ages and occupancy
    always_comb begin
        n_valid  = r_valid;
        n_age    = r_age;
        w_key_we = '0;
        n_occ    = r_occ;
        if ((w_ins || w_look) && w_hit) begin
            // Promote: younger entries age by one
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_match[i]) begin
                    n_age[i] = '0;
                end else if (r_valid[i] && (r_age[i] < w_slot_age)) begin
                    n_age[i] = r_age[i] + 1'b1;
                end
            end
        end else if (w_erase && w_hit) begin
            // Remove: older entries get one step younger
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_match[i]) begin
                    n_valid[i] = 1'b0;
                    n_age[i]   = '0;
                end else if (r_valid[i] && (r_age[i] > w_slot_age)) begin
                    n_age[i] = r_age[i] - 1'b1;
                end
            end
            n_occ = r_occ - 1'b1;
        end else if (w_ins) begin
            // Fresh insert, evicting the oldest first when full
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_free_1h[i]) begin
                    n_valid[i]  = 1'b1;
                    n_age[i]    = '0;
                    w_key_we[i] = 1'b1;
                end else if (w_evict && r_oldest[i]) begin
                    n_valid[i] = 1'b0;
                    n_age[i]   = '0;
                end else if (r_valid[i]) begin
                    n_age[i] = r_age[i] + 1'b1;
                end
            end
            n_occ = w_evict ? r_occ : r_occ + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_cmd.upd) begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            r_age   <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_key_we[i]) r_key[i] <= r_req_key;
            end
            r_res_hit    <= w_hit && (w_ins || w_look || w_erase);
            r_res_ev     <= w_evict;
            r_res_ev_key <= w_evict ? w_ev_key : '0;
        end
    end

    // Value memory: write on insert, read for a lookup
    assign w_mem_addr = w_hit ? w_slot_idx : w_free_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            if (w_ins) begin
                r_mem[w_mem_addr] <= r_req_value;
            end
            r_rd_value <= r_mem[w_mem_addr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_hit    <= r_res_hit;
            r_o_ev     <= r_res_ev;
            r_o_ev_key <= r_res_ev_key;
            if (w_ins) begin
                r_o_rv <= r_req_value;
            end else if (w_look && r_res_hit) begin
                r_o_rv <= r_rd_value;
            end else begin
                r_o_rv <= '0;
            end
        end
    end

    assign o_hit         = r_o_hit;
    assign o_read_value  = r_o_rv;
    assign o_evicted     = r_o_ev;
    assign o_evicted_key = r_o_ev_key;
    assign o_occupancy   = r_occ;

endmodule

`default_nettype wire

// File: hdl/lru_cache_table.sv
// Top level of the LRU cache table: stream ports, APB capacity register,
// controller and datapath. Uses lct_pkg, lct_ctrl and lct_dpath.
//
// Usage:
//   Requests enter on the s_axis channel: tuser holds the action (insert,
//   lookup, erase), tdata holds key and value. Each request gives exactly one
//   result on the m_axis channel: tuser holds hit and evicted, tdata holds the
//   read value and the evicted key.
//   An item is taken, then walks compare, update and result steps; the result
//   step loads the output register for m_axis, and only then is a new item
//   taken. The controller handles one item at a time; the full parallel
//   key compare and the per-entry age update each take one of those steps.
//   The output register holds a finished result while the receiver stalls;
//   the block then waits in the result step, so the next item goes through
//   once the held result is taken.
//   Capacity (APB register 0) is written only while the table is empty; other
//   writes are dropped, 0 is stored as 1 and values above ENTRIES as ENTRIES.
//   Reset clears all entries at once and sets capacity to ENTRIES; the block
//   accepts items in the first cycle after reset.
`default_nettype none

module lru_cache_table #(
    parameter int ENTRIES    = lct_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lct_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lct_pkg::DEF_VALUE_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: key, value (from bit 0 up), zero padded to bytes
    input  wire logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: action
    input  wire logic [1:0]  s_axis_tuser,
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: read_value, evicted_key (from bit 0 up), zero padded to bytes
    output logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: hit, evicted (from bit 0 up)
    output logic [1:0]       m_axis_tuser,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lct_pkg::*;

    localparam int DATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int OCC_W  = $clog2(ENTRIES + 1);

    t_dp_cmd               w_cmd;
    logic [OCC_W-1:0]      r_capacity;
    logic [OCC_W-1:0]      w_occ;
    logic                  w_cfg_we;
    logic                  w_hit;
    logic                  w_ev;
    logic [VALUE_BITS-1:0] w_rv;
    logic [KEY_BITS-1:0]   w_ev_key;

    // Capacity register: clamp and take only while empty
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= OCC_W'(ENTRIES);
        end else if (w_cfg_we && (w_occ == '0)) begin
            if (pwdata == '0) begin
                r_capacity <= OCC_W'(1);
            end else if (pwdata > 32'(ENTRIES)) begin
                r_capacity <= OCC_W'(ENTRIES);
            end else begin
                r_capacity <= pwdata[OCC_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? '0 : 32'(r_capacity);

    lct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    lct_dpath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .OCC_W      (OCC_W)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_capacity    (r_capacity),
        .i_action      (s_axis_tuser),
        .i_key         (s_axis_tdata[KEY_BITS-1:0]),
        .i_value       (s_axis_tdata[KEY_BITS +: VALUE_BITS]),
        .o_hit         (w_hit),
        .o_read_value  (w_rv),
        .o_evicted     (w_ev),
        .o_evicted_key (w_ev_key),
        .o_occupancy   (w_occ)
    );

    // Pack the result
    assign m_axis_tdata = DATA_W'({w_ev_key, w_rv});
    assign m_axis_tuser = {w_ev, w_hit};

    // Checks
    a_occ_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ <= r_capacity)
        else $error("occupancy exceeds capacity");

    a_cap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_capacity != '0)
        else $error("capacity is zero");

    a_cap_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_capacity)) |-> ($past(w_occ) == '0))
        else $error("capacity changed while table not empty");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while previous item in progress");

endmodule

`default_nettype wire
